// ===== rtl/abs_pkg.sv =====
// Shared types and constants for the allocation bitmap search block.
// Used by every module under rtl/; depends on nothing else.
package abs_pkg;

  localparam int unsigned DEF_MAP_SLOTS = 1024;
  localparam int unsigned MODE_W        = 3;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned CFG_W         = 8;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned MAX_WORD_W    = 64;
  localparam int unsigned SLOT_SHIFT    = 3;    // eight slots per map byte
  localparam int unsigned BYTES_RESET   = 128;

  // register index as seen in paddr[APB_AW-1:2]
  localparam logic [APB_AW-3:0] REG_BYTES_IN_USE = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET_FREE  = 3'd0,
    MODE_SET_USED  = 3'd1,
    MODE_TEST_FREE = 3'd2,
    MODE_NEXT_FREE = 3'd3,
    MODE_PREV_FREE = 3'd4
  } mode_e;

  typedef struct packed {
    logic start;     // latch request, read first word
    logic step;      // read next word of a scan
    logic load_res;  // capture result
    logic wr_back;   // write modified word
    logic clr_wr;    // clearing sweep write
  } cmd_t;

  typedef struct packed {
    logic finish;
    logic wr_req;
    logic clr_last;
  } status_t;

  // width that holds the slot limit, an index plus one, and the slot count
  function automatic int unsigned ext_width(input int unsigned slots);
    int unsigned w;
    w = $clog2(slots + 1);
    return (w > POS_W + 1) ? w : POS_W + 1;
  endfunction

endpackage

// ===== rtl/allocation_bitmap_search.sv =====
// Allocation bitmap: set/test/next-free/previous-free over a one-bit-per-slot map.
// A set, test or unused-mode request reads one map word; a search reads the map words it
// touches one after another (at most MAP_SLOTS/64 words, 16 at 1024 slots).
// One request in flight; next is taken the cycle after the result beat leaves.
// Rate is set by the single read port of the map memory, one 64-bit word per cycle.
// After reset a clearing pass writes every map word with in_ready low.
module allocation_bitmap_search #(
  parameter int unsigned MAP_SLOTS = abs_pkg::DEF_MAP_SLOTS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abs_pkg::APB_AW-1:0]  paddr,
  input  logic [abs_pkg::APB_DW-1:0]  pwdata,
  output logic [abs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [abs_pkg::MODE_W-1:0]  mode_i,
  input  logic [abs_pkg::POS_W-1:0]   index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [abs_pkg::POS_W-1:0]   position_o
);
  import abs_pkg::*;

  localparam int unsigned EXT_W = ext_width(MAP_SLOTS);

  cmd_t             cmd;
  status_t          status;
  logic [EXT_W-1:0] limit, last;

  abs_regs #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit),
    .last_o  (last)
  );

  abs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  abs_dpath #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .mode_i     (mode_i),
    .index_i    (index_i),
    .limit_i    (limit),
    .last_i     (last),
    .found_o    (found_o),
    .position_o (position_o)
  );

endmodule

// ===== rtl/abs_regs.sv =====
// APB-style configuration register: bytes_in_use and the derived slot limit.
// Depends on abs_pkg.
module abs_regs #(
  parameter int unsigned MAP_SLOTS = abs_pkg::DEF_MAP_SLOTS,
  localparam int unsigned EXT_W    = abs_pkg::ext_width(MAP_SLOTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abs_pkg::APB_AW-1:0]  paddr,
  input  logic [abs_pkg::APB_DW-1:0]  pwdata,
  output logic [abs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [EXT_W-1:0]            limit_o,
  output logic [EXT_W-1:0]            last_o
);
  import abs_pkg::*;

  localparam int unsigned RST_SLOTS = BYTES_RESET << SLOT_SHIFT;
  localparam int unsigned RST_LIM   = (RST_SLOTS > MAP_SLOTS) ? MAP_SLOTS : RST_SLOTS;

  logic [CFG_W-1:0] bytes_q;
  logic [EXT_W-1:0] limit_q, last_q;
  logic [EXT_W-1:0] slots, limit_d;
  logic             hit_reg, wr_en;

  assign hit_reg = (paddr[APB_AW-1:2] == REG_BYTES_IN_USE);
  assign wr_en   = psel & penable & pwrite & hit_reg;

  // slot count saturates at the map size
  always_comb begin
    slots = '0;
    slots[CFG_W+SLOT_SHIFT-1:0] = {pwdata[CFG_W-1:0], {SLOT_SHIFT{1'b0}}};
    limit_d = (slots > EXT_W'(MAP_SLOTS)) ? EXT_W'(MAP_SLOTS) : slots;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= CFG_W'(BYTES_RESET);
      limit_q <= EXT_W'(RST_LIM);
      last_q  <= EXT_W'(RST_LIM - 1);
    end else if (wr_en) begin
      bytes_q <= pwdata[CFG_W-1:0];
      limit_q <= limit_d;
      last_q  <= limit_d - EXT_W'(1);
    end
  end

  assign prdata  = hit_reg ? {{(APB_DW-CFG_W){1'b0}}, bytes_q} : '0;
  assign pready  = 1'b1;
  assign limit_o = limit_q;
  assign last_o  = last_q;

endmodule

// ===== rtl/abs_dpath.sv =====
// Datapath: map memory (one word per cycle), scan pointer, masked priority
// encoders and result register. Depends on abs_pkg.
module abs_dpath #(
  parameter int unsigned MAP_SLOTS = abs_pkg::DEF_MAP_SLOTS,
  localparam int unsigned EXT_W    = abs_pkg::ext_width(MAP_SLOTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  abs_pkg::cmd_t               cmd_i,
  output abs_pkg::status_t            status_o,
  input  logic [abs_pkg::MODE_W-1:0]  mode_i,
  input  logic [abs_pkg::POS_W-1:0]   index_i,
  input  logic [EXT_W-1:0]            limit_i,
  input  logic [EXT_W-1:0]            last_i,
  output logic                        found_o,
  output logic [abs_pkg::POS_W-1:0]   position_o
);
  import abs_pkg::*;

  localparam int unsigned WORD_W    = (MAP_SLOTS < MAX_WORD_W) ?
                                      (1 << $clog2(MAP_SLOTS)) : MAX_WORD_W;
  localparam int unsigned WB        = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS = (MAP_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic [WORD_W-1:0] mem_q [NUM_WORDS];
  logic [WORD_W-1:0] rd_data_q;

  logic [MODE_W-1:0] mode_q;
  logic [POS_W-1:0]  idx_q;
  logic [EXT_W-1:0]  lo_q;
  logic              empty_q;
  logic [ADDR_W-1:0] cur_q, ptr_q;
  logic              found_q;
  logic [POS_W-1:0]  pos_q;

  logic [EXT_W-1:0]  idx_ext, lo_d, slot_ext;
  logic              prev_in, empty_d;
  logic [ADDR_W-1:0] first_addr, rd_addr, wr_addr;
  logic              rd_en, wr_en;
  logic [WORD_W-1:0] wr_data, mod_word, cand;
  logic [WB-1:0]     lo_enc, hi_enc, enc;
  logic              is_set, is_prev, is_search, at_lo, at_hi, at_end, hit;
  logic              found_d;
  logic [POS_W-1:0]  pos_d;

  // request decode at the accepting edge
  assign idx_ext    = {{(EXT_W-POS_W){1'b0}}, index_i};
  assign prev_in    = (mode_i == MODE_PREV_FREE);
  assign lo_d       = idx_ext + EXT_W'(prev_in);
  assign empty_d    = !(lo_d < limit_i);
  assign first_addr = prev_in ? last_i[WB +: ADDR_W] : idx_ext[WB +: ADDR_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q  <= mode_i;
      idx_q   <= index_i;
      lo_q    <= lo_d;
      empty_q <= empty_d;
    end
  end

  // ptr_q doubles as the clearing sweep counter after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      ptr_q <= ptr_q + ADDR_W'(1);
    end else if (cmd_i.start) begin
      ptr_q <= prev_in ? first_addr - ADDR_W'(1) : first_addr + ADDR_W'(1);
    end else if (cmd_i.step) begin
      ptr_q <= is_prev ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q <= first_addr;
    end else if (cmd_i.step) begin
      cur_q <= ptr_q;
    end
  end

  // map memory: one write port, one registered read port
  assign rd_en   = cmd_i.start | cmd_i.step;
  assign rd_addr = cmd_i.start ? first_addr : ptr_q;
  assign wr_en   = cmd_i.clr_wr | cmd_i.wr_back;
  assign wr_addr = cmd_i.clr_wr ? ptr_q : cur_q;

  always_comb begin
    mod_word = rd_data_q;
    mod_word[idx_q[WB-1:0]] = (mode_q == MODE_SET_USED);
  end

  assign wr_data = cmd_i.clr_wr ? '0 : mod_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // word evaluation: free bits inside [lo, last], lowest or highest wins
  assign is_set    = (mode_q == MODE_SET_FREE) || (mode_q == MODE_SET_USED);
  assign is_prev   = (mode_q == MODE_PREV_FREE);
  assign is_search = (mode_q == MODE_NEXT_FREE) || is_prev;
  assign at_lo     = (cur_q == lo_q[WB +: ADDR_W]);
  assign at_hi     = (cur_q == last_i[WB +: ADDR_W]);
  assign at_end    = is_prev ? at_lo : at_hi;

  always_comb begin
    cand   = '0;
    lo_enc = '0;
    hi_enc = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (!rd_data_q[j] && (!at_lo || WB'(j) >= lo_q[WB-1:0]) &&
          (!at_hi || WB'(j) <= last_i[WB-1:0])) begin
        cand[j] = 1'b1;
      end
    end
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        lo_enc = WB'(j);
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (cand[j]) begin
        hi_enc = WB'(j);
      end
    end
  end

  assign hit = |cand;
  assign enc = is_prev ? hi_enc : lo_enc;

  always_comb begin
    slot_ext = '0;
    slot_ext[ADDR_W+WB-1:0] = {cur_q, enc};
  end

  always_comb begin
    found_d = 1'b0;
    pos_d   = '0;
    case (mode_q)
      MODE_SET_FREE, MODE_SET_USED: begin
        found_d = !empty_q;
        pos_d   = idx_q;
      end
      MODE_TEST_FREE: begin
        found_d = !empty_q && !rd_data_q[idx_q[WB-1:0]];
        pos_d   = idx_q;
      end
      MODE_NEXT_FREE, MODE_PREV_FREE: begin
        found_d = !empty_q && hit;
        pos_d   = found_d ? slot_ext[POS_W-1:0] : '0;
      end
      default: begin
        found_d = 1'b0;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      found_q <= found_d;
      pos_q   <= pos_d;
    end
  end

  assign status_o.finish   = !is_search || empty_q || hit || at_end;
  assign status_o.wr_req   = is_set && !empty_q;
  assign status_o.clr_last = (ptr_q == ADDR_W'(NUM_WORDS - 1));

  assign found_o    = found_q;
  assign position_o = pos_q;

endmodule

// ===== rtl/abs_ctrl.sv =====
// Controller FSM: clearing sweep, request accept, word scan, result beat.
// Depends on abs_pkg.
module abs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  abs_pkg::status_t  status_i,
  output abs_pkg::cmd_t     cmd_o
);
  import abs_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WORK,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WORK;
        end
      end
      ST_WORK: begin
        if (status_i.finish) begin
          cmd_o.load_res = 1'b1;
          cmd_o.wr_back  = status_i.wr_req;
          state_d        = ST_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= (state_d == ST_IDLE);
      out_valid_q <= (state_d == ST_RESP);
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/abs_checker.sv =====
// Port-level checks for allocation_bitmap_search, bound to the top level.
// Depends on abs_pkg.
module abs_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       found_o,
  input logic [abs_pkg::POS_W-1:0]  position_o
);
  import abs_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("result beat changed while stalled");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken before result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while result pending");

  // a result beat that was taken is not repeated
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind allocation_bitmap_search abs_checker u_abs_checker (.*);
